### hdl/twvt_pkg.sv
// Shared types and constants for the rolling-window trade volume tracker.
// Used by the channel interfaces, the divider and the top level; depends on nothing.
package twvt_pkg;

    localparam int EVENT_TIME_W = 64;
    localparam int AMOUNT_W     = 40;
    localparam int VOLUME_W     = 48;
    localparam int FRAC_W       = 16;
    localparam int PROGRESS_W   = FRAC_W + 1;
    localparam int DAYS_W       = 9;
    localparam int WINDOW_NS_W  = 56;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 48;

    localparam int SAMPLE_DEPTH_DEF = 256;

    localparam logic [WINDOW_NS_W-1:0] NS_PER_DAY      = 56'd86_400_000_000_000;
    localparam logic [DAYS_W-1:0]      WINDOW_DAYS_RST = 9'd30;
    localparam logic [WINDOW_NS_W-1:0] WINDOW_NS_RST   =
        WINDOW_NS_W'(WINDOW_DAYS_RST) * NS_PER_DAY;
    localparam logic [PROGRESS_W-1:0]  PROGRESS_ONE    = PROGRESS_W'(1) << FRAC_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIER_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_DAYS    = 1'b1;

    typedef logic [VOLUME_W-1:0] t_volume;

endpackage

### hdl/twvt_trade_if.sv
// Trade input channel: valid/ready handshake with timestamp and amount.
// Depends on twvt_pkg for the field widths.
interface twvt_trade_if;
    logic                               valid;
    logic                               ready;
    logic [twvt_pkg::EVENT_TIME_W-1:0]  event_time;
    logic [twvt_pkg::AMOUNT_W-1:0]      trade_amount;

    modport source (output valid, event_time, trade_amount, input ready);
    modport sink   (input valid, event_time, trade_amount, output ready);
endinterface

### hdl/twvt_result_if.sv
// Result output channel: valid/ready handshake with volume, progress and flags.
// Depends on twvt_pkg for the field widths.
interface twvt_result_if;
    logic                               valid;
    logic                               ready;
    logic [twvt_pkg::VOLUME_W-1:0]      window_volume;
    logic [twvt_pkg::PROGRESS_W-1:0]    tier_fraction;
    logic                               near_crossing;
    logic                               overflow;

    modport source (output valid, window_volume, tier_fraction, near_crossing, overflow,
                    input ready);
    modport sink   (input valid, window_volume, tier_fraction, near_crossing, overflow,
                    output ready);
endinterface

### hdl/twvt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module twvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/twvt_div.sv
// Restoring divider, one quotient bit per cycle, for dividend below divisor.
// Gives the FRAC_W fraction bits of dividend / divisor. Depends on twvt_pkg.
module twvt_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  twvt_pkg::t_volume             i_dividend,
    input  twvt_pkg::t_volume             i_divisor,
    output logic                          o_done,
    output logic [twvt_pkg::FRAC_W-1:0]   o_quot
);

    localparam int W     = twvt_pkg::VOLUME_W;
    localparam int CNT_W = $clog2(twvt_pkg::FRAC_W);

    logic                         r_busy;
    logic                         r_done;
    logic [CNT_W-1:0]             r_cnt;
    logic [W-1:0]                 r_rem;
    logic [W-1:0]                 r_dsr;
    logic [twvt_pkg::FRAC_W-1:0]  r_quot;

    logic [W:0]                   rem2;
    logic                         take;

    // remainder stays below the divisor, so doubling fits in W+1 bits
    assign rem2 = {r_rem, 1'b0};
    assign take = rem2 >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(twvt_pkg::FRAC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_dsr  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= take ? W'(rem2 - {1'b0, r_dsr}) : rem2[W-1:0];
            r_quot <= {r_quot[twvt_pkg::FRAC_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### hdl/timed_window_volume_tracker_top.sv
// Rolling-window trade volume tracker: sample store, expiry sequencer, output register.
// Depends on twvt_pkg, twvt_trade_if, twvt_result_if, twvt_ram and twvt_div.
//
//   channel    dir  handshake              payload
//   i_trade    in   valid / ready          event_time[63:0], trade_amount[39:0]
//   o_result   out  valid / ready          window_volume[47:0], tier_fraction[16:0],
//                                          near_crossing, overflow
//   i_cfg_*    in   i_cfg_we, no back-pressure  i_cfg_idx, i_cfg_data[47:0]
//
// A trade passes through idle, insert, the tier stage and hand-over, plus the divider when it
// runs; before insert come the oldest-sample checks, one RAM read and one compare/subtract each:
// one per sample retired by age, plus one when samples remain (it forces out a full store).
// Input is taken only in the idle state; a finished result waits in the output register
// and the next trade is taken meanwhile; only loading a new result waits on o_result.ready.
// Active-low sync reset clears state, pointers, count, total, cfg, out valid; no RAM clear.
module timed_window_volume_tracker_top #(
    parameter int SAMPLE_DEPTH = twvt_pkg::SAMPLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    twvt_trade_if.sink                       i_trade,
    twvt_result_if.source                    o_result,
    input  logic                             i_cfg_we,
    input  logic [twvt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [twvt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int PTR_W  = $clog2(SAMPLE_DEPTH);
    localparam int CNT_W  = $clog2(SAMPLE_DEPTH + 1);
    localparam int TIME_W = twvt_pkg::EVENT_TIME_W;
    localparam int AMT_W  = twvt_pkg::AMOUNT_W;
    localparam int VOL_W  = twvt_pkg::VOLUME_W;
    localparam int WORD_W = TIME_W + AMT_W;
    localparam int CMP_W  = VOL_W + 4;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SAMPLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SAMPLE_DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_INSERT = 3'd3;
    localparam logic [2:0] S_PREP   = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]                          r_state, n_state;
    logic [TIME_W-1:0]                   r_now, n_now;
    logic [AMT_W-1:0]                    r_amt, n_amt;
    logic [PTR_W-1:0]                    r_oldest, n_oldest;
    logic [PTR_W-1:0]                    r_newest, n_newest;
    logic [CNT_W-1:0]                    r_count, n_count;
    twvt_pkg::t_volume                   r_total, n_total;
    logic                                r_ovf, n_ovf;
    logic [twvt_pkg::PROGRESS_W-1:0]     r_prog, n_prog;
    logic                                r_near, n_near;

    twvt_pkg::t_volume                   r_thr;
    logic [twvt_pkg::WINDOW_NS_W-1:0]    r_window_ns;

    logic                                r_out_valid;
    twvt_pkg::t_volume                   r_out_volume;
    logic [twvt_pkg::PROGRESS_W-1:0]     r_out_prog;
    logic                                r_out_near;
    logic                                r_out_ovf;

    logic                                ram_we;
    logic [WORD_W-1:0]                   ram_rdata;
    logic [TIME_W-1:0]                   old_time;
    twvt_pkg::t_volume                   old_amt;
    logic [TIME_W-1:0]                   age;
    logic                                expired;
    twvt_pkg::t_volume                   total_less_old;
    logic [VOL_W:0]                      total_sum;
    logic                                near_cmp;
    logic                                div_start;
    logic                                div_done;
    logic [twvt_pkg::FRAC_W-1:0]         div_quot;
    logic                                accept;
    logic                                out_load;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    twvt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SAMPLE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_newest),
        .i_wdata ({r_now, r_amt}),
        .i_raddr (r_oldest),
        .o_rdata (ram_rdata)
    );

    twvt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_total),
        .i_divisor  (r_thr),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign old_time       = ram_rdata[WORD_W-1:AMT_W];
    assign old_amt        = VOL_W'(ram_rdata[AMT_W-1:0]);
    assign age            = r_now - old_time;
    assign expired        = age > TIME_W'(r_window_ns);
    assign total_less_old = (old_amt > r_total) ? '0 : r_total - old_amt;
    assign total_sum      = {1'b0, r_total} + (VOL_W + 1)'(r_amt);
    assign near_cmp       = (CMP_W'(r_total) * CMP_W'(10)) > (CMP_W'(r_thr) * CMP_W'(9));

    assign accept   = i_trade.valid && i_trade.ready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_result.ready);
    assign ram_we   = (r_state == S_INSERT);
    assign div_start = (r_state == S_PREP) && (r_thr != '0) && (r_total < r_thr);

    always_comb begin
        n_state  = r_state;
        n_now    = r_now;
        n_amt    = r_amt;
        n_oldest = r_oldest;
        n_newest = r_newest;
        n_count  = r_count;
        n_total  = r_total;
        n_ovf    = r_ovf;
        n_prog   = r_prog;
        n_near   = r_near;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_now   = i_trade.event_time;
                    n_amt   = i_trade.trade_amount;
                    n_ovf   = 1'b0;
                    n_state = (r_count == '0) ? S_INSERT : S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                // retire the oldest sample if aged out, or force it out when full
                if (expired || r_count == CNT_FULL) begin
                    n_total  = total_less_old;
                    n_oldest = advance(r_oldest);
                    n_count  = r_count - CNT_W'(1);
                end
                if (expired) begin
                    n_state = (r_count == CNT_W'(1)) ? S_INSERT : S_READ;
                end else begin
                    n_ovf   = (r_count == CNT_FULL);
                    n_state = S_INSERT;
                end
            end
            S_INSERT: begin
                n_newest = advance(r_newest);
                n_count  = r_count + CNT_W'(1);
                n_total  = total_sum[VOL_W] ? '1 : total_sum[VOL_W-1:0];
                n_state  = S_PREP;
            end
            S_PREP: begin
                if (r_thr == '0) begin
                    n_prog  = '0;
                    n_near  = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_near = near_cmp;
                    if (r_total >= r_thr) begin
                        n_prog  = twvt_pkg::PROGRESS_ONE;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_prog  = {1'b0, div_quot};
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_oldest <= '0;
            r_newest <= '0;
            r_count  <= '0;
            r_total  <= '0;
        end else begin
            r_state  <= n_state;
            r_oldest <= n_oldest;
            r_newest <= n_newest;
            r_count  <= n_count;
            r_total  <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now  <= n_now;
        r_amt  <= n_amt;
        r_ovf  <= n_ovf;
        r_prog <= n_prog;
        r_near <= n_near;
    end

    // configuration: the window length in ns is formed once, at the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= '0;
            r_window_ns <= twvt_pkg::WINDOW_NS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                twvt_pkg::CFG_TIER_THRESHOLD: r_thr <= i_cfg_data[VOL_W-1:0];
                twvt_pkg::CFG_WINDOW_DAYS: begin
                    r_window_ns <= twvt_pkg::WINDOW_NS_W'(i_cfg_data[twvt_pkg::DAYS_W-1:0])
                                   * twvt_pkg::NS_PER_DAY;
                end
                default: begin
                    r_thr <= r_thr;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_volume <= r_total;
            r_out_prog   <= r_prog;
            r_out_near   <= r_near;
            r_out_ovf    <= r_ovf;
        end
    end

    assign i_trade.ready          = (r_state == S_IDLE);
    assign o_result.valid         = r_out_valid;
    assign o_result.window_volume = r_out_volume;
    assign o_result.tier_fraction = r_out_prog;
    assign o_result.near_crossing = r_out_near;
    assign o_result.overflow      = r_out_ovf;

endmodule
